// ----- hw/rtl/vms_pkg.sv -----
package vms_pkg;

   // command codes carried in the op field
   typedef enum logic [2:0] {
      OP_OPEN        = 3'd0,
      OP_CLOSE       = 3'd1,
      OP_STOP        = 3'd2,
      OP_SAFETY      = 3'd3,
      OP_UPDATE      = 3'd4,
      OP_CLEAR_FAULT = 3'd5,
      OP_RESET_CYCLE = 3'd6
   } vms_op_type;

   // controller mode
   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_OPENING  = 3'd1,
      MODE_CLOSING  = 3'd2,
      MODE_STOPPING = 3'd3,
      MODE_FAULT    = 3'd4
   } vms_mode_type;

   // motion direction
   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_OPEN  = 2'd1,
      DIR_CLOSE = 2'd2
   } vms_dir_type;

   // result status
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_DRIVER  = 2'd2
   } vms_status_type;

   // driver action bits
   localparam logic [3:0] ACT_SAFE  = 4'b0001;
   localparam logic [3:0] ACT_STOP  = 4'b0010;
   localparam logic [3:0] ACT_OPEN  = 4'b0100;
   localparam logic [3:0] ACT_CLOSE = 4'b1000;

   localparam logic [6:0] DUTY_MAX = 7'd100;

   // register port: byte address, register index in bit 2
   localparam int   CSR_ADDR_W   = 3;
   localparam logic CSR_IDX_DUTY = 1'b0;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] now_time_ms;
      logic        allow_start;
      logic        allow_run;
      logic        want_stop;
      logic        want_close;
      logic        fault_in;
      logic        hal_ok;
   } vms_req_type;

   typedef struct packed {
      vms_mode_type mode;
      vms_dir_type  dir;
      logic         running;
      logic         block;
      logic [31:0]  runtime;
      logic [31:0]  count;
      vms_dir_type  lastcmd;
      logic [31:0]  stamp;
   } vms_state_type;

   typedef struct packed {
      vms_state_type  s;
      logic [3:0]     acts;
      logic [6:0]     duty;
      vms_status_type status;
   } vms_work_type;

   typedef struct packed {
      vms_status_type status_code;
      vms_mode_type   ctrl_state;
      vms_dir_type    motion_dir;
      logic           motor_on;
      logic           blocked;
      logic [31:0]    run_time_ms;
      logic [31:0]    ops_done;
      vms_dir_type    last_dir;
      logic [3:0]     driver_actions;
      logic [6:0]     drive_duty;
   } vms_rsp_type;

endpackage

// ----- hw/rtl/valve_motor_supervisor.sv -----
// Valve motor supervisor. Each accepted item is one command (open, close, stop,
// apply safety, time update, clear fault, reset cycle) and yields exactly one
// result carrying the status, the new controller state, the driver actions
// issued and the duty handed over with a start. One item is taken every clock
// cycle while the result channel does not stall; a result passes the input
// register, then the command engine's state update into the result register.
// The user must write the duty register at byte address 0 over the APB port
// only while no command is in flight; the block itself does not enforce this.
// Values above 100 are issued as 100.
module valve_motor_supervisor (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_op,
   input  logic [31:0]                    req_now_time_ms,
   input  logic                           req_allow_start,
   input  logic                           req_allow_run,
   input  logic                           req_want_stop,
   input  logic                           req_want_close,
   input  logic                           req_fault_in,
   input  logic                           req_hal_ok,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status_code,
   output logic [2:0]                     rsp_ctrl_state,
   output logic [1:0]                     rsp_motion_dir,
   output logic                           rsp_motor_on,
   output logic                           rsp_blocked,
   output logic [31:0]                    rsp_run_time_ms,
   output logic [31:0]                    rsp_ops_done,
   output logic [1:0]                     rsp_last_dir,
   output logic [3:0]                     rsp_driver_actions,
   output logic [6:0]                     rsp_drive_duty,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [vms_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   vms_pkg::vms_req_type req_item;
   vms_pkg::vms_req_type item;
   vms_pkg::vms_rsp_type result;
   vms_pkg::vms_rsp_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 item_valid;
   logic                 out_ready;
   logic                 fire;
   logic [6:0]           duty_cfg;

   assign req_item.op          = req_op;
   assign req_item.now_time_ms = req_now_time_ms;
   assign req_item.allow_start = req_allow_start;
   assign req_item.allow_run   = req_allow_run;
   assign req_item.want_stop   = req_want_stop;
   assign req_item.want_close  = req_want_close;
   assign req_item.fault_in    = req_fault_in;
   assign req_item.hal_ok      = req_hal_ok;

   vms_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .duty_cfg (duty_cfg)
   );

   vms_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (out_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   // result register frees when empty or its transfer completes
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid && out_ready;

   vms_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (item),
      .duty_cfg (duty_cfg),
      .result   (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status_code    = rsp_ff.status_code;
   assign rsp_ctrl_state     = rsp_ff.ctrl_state;
   assign rsp_motion_dir     = rsp_ff.motion_dir;
   assign rsp_motor_on       = rsp_ff.motor_on;
   assign rsp_blocked        = rsp_ff.blocked;
   assign rsp_run_time_ms    = rsp_ff.run_time_ms;
   assign rsp_ops_done       = rsp_ff.ops_done;
   assign rsp_last_dir       = rsp_ff.last_dir;
   assign rsp_driver_actions = rsp_ff.driver_actions;
   assign rsp_drive_duty     = rsp_ff.drive_duty;

`ifndef SYNTHESIS
   a_duty_only_on_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.drive_duty != 7'd0) |->
         (rsp_ff.driver_actions[2] || rsp_ff.driver_actions[3]))
      else $error("duty reported without a start action");

   a_duty_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.drive_duty <= vms_pkg::DUTY_MAX))
      else $error("issued duty above full scale");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !fire) |=> item_valid)
      else $error("pending command lost while result stage busy");
`endif

endmodule

// ----- hw/rtl/vms_csr.sv -----
module vms_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [vms_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output logic [6:0]                      duty_cfg
);

   logic [6:0] duty_ff;
   logic [6:0] duty_in;
   logic       duty_sel;

   assign duty_sel = (paddr[2] == vms_pkg::CSR_IDX_DUTY);

   // duty register write on the access phase
   always_comb begin
      duty_in = duty_ff;
      if (psel && penable && pwrite && duty_sel) begin
         duty_in = pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= '0;
      end else begin
         duty_ff <= duty_in;
      end
   end

   // read back
   assign prdata   = duty_sel ? {25'd0, duty_ff} : 32'd0;
   assign pready   = 1'b1;
   assign duty_cfg = duty_ff;

endmodule

// ----- hw/rtl/vms_in_reg.sv -----
module vms_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vms_pkg::vms_req_type req_item,
   input  logic                 take,
   output logic                 item_valid,
   output vms_pkg::vms_req_type item
);

   logic                 valid_ff;
   logic                 valid_in;
   vms_pkg::vms_req_type item_ff;

   // hold the item while the engine cannot take it
   assign req_stall = valid_ff && !take;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture on transfer
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- hw/rtl/vms_engine.sv -----
module vms_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  vms_pkg::vms_req_type item,
   input  logic [6:0]           duty_cfg,
   output vms_pkg::vms_rsp_type result
);

   vms_pkg::vms_state_type state_ff;
   vms_pkg::vms_state_type state_in;
   vms_pkg::vms_work_type  work;
   logic [6:0]             duty_lim;
   logic                   halted;

   // release the active operation
   function automatic vms_pkg::vms_state_type drop_active(vms_pkg::vms_state_type s);
      vms_pkg::vms_state_type r;
      r         = s;
      r.running = 1'b0;
      r.dir     = vms_pkg::DIR_NONE;
      r.runtime = '0;
      r.stamp   = '0;
      return r;
   endfunction

   // stop command, also used by the safety path
   function automatic vms_pkg::vms_work_type stop_cmd(vms_pkg::vms_work_type w, logic ok);
      vms_pkg::vms_work_type r;
      r = w;
      if (!r.s.running) begin
         r.acts = r.acts | vms_pkg::ACT_SAFE;
         if (!ok) begin
            r.s.mode = vms_pkg::MODE_FAULT;
            r.status = vms_pkg::ST_DRIVER;
         end else begin
            if (r.s.mode != vms_pkg::MODE_FAULT) begin
               r.s.mode = vms_pkg::MODE_IDLE;
            end
            r.status = vms_pkg::ST_OK;
         end
      end else begin
         r.s.mode = vms_pkg::MODE_STOPPING;
         r.acts   = r.acts | vms_pkg::ACT_STOP;
         if (!ok) begin
            r.status = vms_pkg::ST_DRIVER;
         end else begin
            r.s       = drop_active(r.s);
            r.s.count = r.s.count + 32'd1;
            r.s.mode  = vms_pkg::MODE_IDLE;
            r.status  = vms_pkg::ST_OK;
         end
      end
      return r;
   endfunction

   // motor start in one direction
   function automatic vms_pkg::vms_work_type begin_motion(vms_pkg::vms_work_type w,
                                                          vms_pkg::vms_dir_type  dir,
                                                          logic [31:0]           now,
                                                          logic                  ok,
                                                          logic [6:0]            duty);
      vms_pkg::vms_work_type r;
      r      = w;
      r.acts = r.acts | ((dir == vms_pkg::DIR_OPEN) ? vms_pkg::ACT_OPEN : vms_pkg::ACT_CLOSE);
      r.duty = duty;
      if (!ok) begin
         r.status = vms_pkg::ST_DRIVER;
      end else begin
         r.s.dir     = dir;
         r.s.lastcmd = dir;
         r.s.running = 1'b1;
         r.s.runtime = '0;
         r.s.stamp   = now;
         r.s.mode    = (dir == vms_pkg::DIR_OPEN) ? vms_pkg::MODE_OPENING
                                                  : vms_pkg::MODE_CLOSING;
         r.status    = vms_pkg::ST_OK;
      end
      return r;
   endfunction

   assign duty_lim = (duty_cfg > vms_pkg::DUTY_MAX) ? vms_pkg::DUTY_MAX : duty_cfg;

   // next state: one command against the current state
   always_comb begin
      work.s      = state_ff;
      work.acts   = '0;
      work.duty   = '0;
      work.status = vms_pkg::ST_OK;
      halted      = 1'b0;
      unique case (vms_pkg::vms_op_type'(item.op)) inside
         vms_pkg::OP_OPEN, vms_pkg::OP_CLOSE: begin
            if (work.s.mode == vms_pkg::MODE_FAULT || work.s.block || work.s.running) begin
               work.status = vms_pkg::ST_INVALID;
            end else begin
               work = begin_motion(work,
                                   (item.op == vms_pkg::OP_OPEN) ? vms_pkg::DIR_OPEN
                                                                 : vms_pkg::DIR_CLOSE,
                                   item.now_time_ms, item.hal_ok, duty_lim);
            end
         end
         vms_pkg::OP_STOP: begin
            work = stop_cmd(work, item.hal_ok);
         end
         vms_pkg::OP_SAFETY: begin
            if (item.fault_in) begin
               work.s.block = 1'b1;
               work.acts    = work.acts | vms_pkg::ACT_SAFE;
               work.s.mode  = vms_pkg::MODE_FAULT;
               if (!item.hal_ok) begin
                  work.s.running = 1'b0;
                  work.s.dir     = vms_pkg::DIR_NONE;
                  work.status    = vms_pkg::ST_DRIVER;
               end else begin
                  work.s = drop_active(work.s);
               end
            end else begin
               // explicit stop request
               if (item.want_stop) begin
                  work = stop_cmd(work, item.hal_ok);
                  if (work.status != vms_pkg::ST_OK) begin
                     halted = 1'b1;
                  end
               end
               // loss of run permission
               if (!halted && !item.allow_run && work.s.running) begin
                  work = stop_cmd(work, item.hal_ok);
                  if (work.status != vms_pkg::ST_OK) begin
                     halted = 1'b1;
                  end
               end
               if (!halted) begin
                  // block latch follows start permission unless faulted
                  if (!item.allow_start) begin
                     work.s.block = 1'b1;
                  end else if (work.s.mode != vms_pkg::MODE_FAULT) begin
                     work.s.block = 1'b0;
                  end
                  // safety close bypasses the block latch
                  if (item.want_close) begin
                     if (work.s.mode == vms_pkg::MODE_FAULT || work.s.running ||
                         !item.allow_run) begin
                        work.status = vms_pkg::ST_INVALID;
                     end else begin
                        work = begin_motion(work, vms_pkg::DIR_CLOSE, item.now_time_ms,
                                            item.hal_ok, duty_lim);
                     end
                  end
               end
            end
         end
         vms_pkg::OP_UPDATE: begin
            if (work.s.running) begin
               work.s.runtime = item.now_time_ms - work.s.stamp;
            end
         end
         vms_pkg::OP_CLEAR_FAULT: begin
            if (work.s.mode != vms_pkg::MODE_FAULT) begin
               work.status = vms_pkg::ST_INVALID;
            end else begin
               work.acts = work.acts | vms_pkg::ACT_SAFE;
               if (!item.hal_ok) begin
                  work.status = vms_pkg::ST_DRIVER;
               end else begin
                  work.s       = drop_active(work.s);
                  work.s.mode  = vms_pkg::MODE_IDLE;
                  work.s.block = 1'b1;
               end
            end
         end
         vms_pkg::OP_RESET_CYCLE: begin
            if (work.s.running || work.s.mode == vms_pkg::MODE_FAULT) begin
               work.status = vms_pkg::ST_INVALID;
            end else begin
               work.s.runtime = '0;
               work.s.stamp   = '0;
            end
         end
         default: begin
            work.status = vms_pkg::ST_INVALID;
         end
      endcase
   end

   // state update on each processed item
   always_comb begin
      state_in = state_ff;
      if (fire) begin
         state_in = work.s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode    <= vms_pkg::MODE_IDLE;
         state_ff.dir     <= vms_pkg::DIR_NONE;
         state_ff.running <= 1'b0;
         state_ff.block   <= 1'b0;
         state_ff.runtime <= '0;
         state_ff.count   <= '0;
         state_ff.lastcmd <= vms_pkg::DIR_NONE;
         state_ff.stamp   <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result fields from the updated state
   always_comb begin
      result.status_code    = work.status;
      result.ctrl_state     = work.s.mode;
      result.motion_dir     = work.s.dir;
      result.motor_on       = work.s.running;
      result.blocked        = work.s.block;
      result.run_time_ms    = work.s.runtime;
      result.ops_done       = work.s.count;
      result.last_dir       = work.s.lastcmd;
      result.driver_actions = work.acts;
      result.drive_duty     = work.duty;
   end

`ifndef SYNTHESIS
   a_run_has_dir: assert property (@(posedge clock) disable iff (reset)
      state_ff.running == (state_ff.dir != vms_pkg::DIR_NONE))
      else $error("running flag and direction disagree");

   a_run_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff.running |-> (state_ff.mode == vms_pkg::MODE_OPENING ||
                            state_ff.mode == vms_pkg::MODE_CLOSING ||
                            state_ff.mode == vms_pkg::MODE_STOPPING))
      else $error("motor running outside an active mode");

   a_count_on_stop: assert property (@(posedge clock) disable iff (reset)
      (fire && work.s.count != state_ff.count) |-> work.acts[1])
      else $error("operation count moved without a stop action");
`endif

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   import vms_pkg::*;

   // op field value with no command behind it
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 182;
   localparam logic [6:0] DUTY_PLAN [0:5] = '{7'd0, 7'd100, 7'd101, 7'd127, 7'd1, 7'd99};

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic [31:0] req_now_time_ms = '0;
   logic        req_allow_start = 1'b0;
   logic        req_allow_run = 1'b0;
   logic        req_want_stop = 1'b0;
   logic        req_want_close = 1'b0;
   logic        req_fault_in = 1'b0;
   logic        req_hal_ok = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status_code;
   logic [2:0]  rsp_ctrl_state;
   logic [1:0]  rsp_motion_dir;
   logic        rsp_motor_on;
   logic        rsp_blocked;
   logic [31:0] rsp_run_time_ms;
   logic [31:0] rsp_ops_done;
   logic [1:0]  rsp_last_dir;
   logic [3:0]  rsp_driver_actions;
   logic [6:0]  rsp_drive_duty;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   valve_motor_supervisor dut (.*);

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // pending commands and the reports they should produce
   vms_req_type command_queue [$];
   vms_rsp_type awaited_reports [$];
   vms_req_type active_cmd;

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   logic [31:0] tick_now = '0;

   // supervisor state as the testbench tracks it
   vms_mode_type sup_mode = MODE_IDLE;
   vms_dir_type  sup_dir = DIR_NONE;
   vms_dir_type  sup_lastdir = DIR_NONE;
   logic         sup_running = 1'b0;
   logic         sup_block = 1'b0;
   logic [31:0]  sup_runtime = '0;
   logic [31:0]  sup_count = '0;
   logic [31:0]  sup_stamp = '0;
   logic [6:0]   sup_duty = '0;

   // per-command scratch: driver calls issued, duty handed over, driver outcome
   logic [3:0]   step_acts;
   logic [6:0]   step_duty;
   logic         step_hal;

   function automatic void clear_motion();
      sup_running = 1'b0;
      sup_dir = DIR_NONE;
      sup_runtime = '0;
      sup_stamp = '0;
   endfunction

   function automatic vms_status_type start_motion(vms_dir_type d, logic [31:0] now);
      step_acts |= (d == DIR_OPEN) ? ACT_OPEN : ACT_CLOSE;
      step_duty = (sup_duty > DUTY_MAX) ? DUTY_MAX : sup_duty;
      if (!step_hal) return ST_DRIVER;
      sup_dir = d;
      sup_lastdir = d;
      sup_running = 1'b1;
      sup_runtime = '0;
      sup_stamp = now;
      sup_mode = (d == DIR_OPEN) ? MODE_OPENING : MODE_CLOSING;
      return ST_OK;
   endfunction

   // stop the motor, or force safe when nothing runs
   function automatic vms_status_type halt_motor();
      if (!sup_running) begin
         step_acts |= ACT_SAFE;
         if (!step_hal) begin
            sup_mode = MODE_FAULT;
            return ST_DRIVER;
         end
         if (sup_mode != MODE_FAULT) sup_mode = MODE_IDLE;
         return ST_OK;
      end
      sup_mode = MODE_STOPPING;
      step_acts |= ACT_STOP;
      if (!step_hal) return ST_DRIVER;
      clear_motion();
      sup_count = sup_count + 32'd1;
      sup_mode = MODE_IDLE;
      return ST_OK;
   endfunction

   // safety input in priority order: fault, stop, run, start, close
   function automatic vms_status_type safety_command(vms_req_type r);
      vms_status_type st;
      if (r.fault_in) begin
         sup_block = 1'b1;
         step_acts |= ACT_SAFE;
         sup_mode = MODE_FAULT;
         if (!step_hal) begin
            sup_running = 1'b0;
            sup_dir = DIR_NONE;
            return ST_DRIVER;
         end
         clear_motion();
         return ST_OK;
      end
      if (r.want_stop) begin
         st = halt_motor();
         if (st != ST_OK) return st;
      end
      if (!r.allow_run && sup_running) begin
         st = halt_motor();
         if (st != ST_OK) return st;
      end
      if (!r.allow_start) sup_block = 1'b1;
      else if (sup_mode != MODE_FAULT) sup_block = 1'b0;
      if (r.want_close) begin
         if (sup_mode == MODE_FAULT || sup_running || !r.allow_run) return ST_INVALID;
         return start_motion(DIR_CLOSE, r.now_time_ms);
      end
      return ST_OK;
   endfunction

   // advance the tracked state by one command and build its report
   function automatic vms_rsp_type apply_command(vms_req_type r);
      vms_status_type st;
      vms_rsp_type    res;
      step_acts = '0;
      step_duty = '0;
      step_hal = r.hal_ok;
      case (r.op) inside
         OP_OPEN, OP_CLOSE: begin
            if (sup_mode == MODE_FAULT || sup_block || sup_running) st = ST_INVALID;
            else st = start_motion((r.op == OP_OPEN) ? DIR_OPEN : DIR_CLOSE, r.now_time_ms);
         end
         OP_STOP: st = halt_motor();
         OP_SAFETY: st = safety_command(r);
         OP_UPDATE: begin
            if (sup_running) sup_runtime = r.now_time_ms - sup_stamp;
            st = ST_OK;
         end
         OP_CLEAR_FAULT: begin
            if (sup_mode != MODE_FAULT) begin
               st = ST_INVALID;
            end else begin
               step_acts |= ACT_SAFE;
               if (!step_hal) begin
                  st = ST_DRIVER;
               end else begin
                  clear_motion();
                  sup_mode = MODE_IDLE;
                  sup_block = 1'b1;
                  st = ST_OK;
               end
            end
         end
         OP_RESET_CYCLE: begin
            if (sup_running || sup_mode == MODE_FAULT) begin
               st = ST_INVALID;
            end else begin
               sup_runtime = '0;
               sup_stamp = '0;
               st = ST_OK;
            end
         end
         default: st = ST_INVALID;
      endcase
      res.status_code = st;
      res.ctrl_state = sup_mode;
      res.motion_dir = sup_dir;
      res.motor_on = sup_running;
      res.blocked = sup_block;
      res.run_time_ms = sup_runtime;
      res.ops_done = sup_count;
      res.last_dir = sup_lastdir;
      res.driver_actions = step_acts;
      res.drive_duty = step_duty;
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic queue_cmd(input logic [2:0] op, input logic [31:0] now,
                            input int a_start, input int a_run, input int w_stop,
                            input int w_close, input int flt, input int ok);
      vms_req_type c;
      c.op = op;
      c.now_time_ms = now;
      c.allow_start = a_start[0];
      c.allow_run = a_run[0];
      c.want_stop = w_stop[0];
      c.want_close = w_close[0];
      c.fault_in = flt[0];
      c.hal_ok = ok[0];
      command_queue.push_back(c);
   endtask

   // mostly motion commands and ticks with a moving clock, some noise
   function automatic vms_req_type random_cmd();
      vms_req_type c;
      int pick;
      pick = $urandom_range(99);
      if (pick < 18) c.op = OP_OPEN;
      else if (pick < 33) c.op = OP_CLOSE;
      else if (pick < 48) c.op = OP_STOP;
      else if (pick < 68) c.op = OP_SAFETY;
      else if (pick < 84) c.op = OP_UPDATE;
      else if (pick < 91) c.op = OP_CLEAR_FAULT;
      else if (pick < 97) c.op = OP_RESET_CYCLE;
      else c.op = OP_UNUSED;
      pick = $urandom_range(99);
      if (pick < 5) tick_now = $urandom();
      else if (pick < 10) tick_now = tick_now + $urandom();
      else tick_now = tick_now + $urandom_range(1000);
      c.now_time_ms = tick_now;
      c.allow_start = ($urandom_range(99) < 80);
      c.allow_run = ($urandom_range(99) < 80);
      c.want_stop = ($urandom_range(99) < 20);
      c.want_close = ($urandom_range(99) < 35);
      c.fault_in = ($urandom_range(99) < 8);
      c.hal_ok = ($urandom_range(99) < 88);
      return c;
   endfunction

   // register write of the duty, then read back
   task automatic write_duty(input logic [31:0] word);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {CSR_IDX_DUTY, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sup_duty = word[6:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("prdata", {25'd0, sup_duty}, prdata);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // every command taken and every report back, then let the pipeline settle
   task automatic wait_drained();
      @(negedge clock);
      while (command_queue.size() != 0 || req_valid || awaited_reports.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // command driver: predict on each transfer, then present the next command
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) awaited_reports.push_back(apply_command(active_cmd));
         if (!req_valid || !req_stall) begin
            if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               active_cmd = command_queue.pop_front();
               req_valid <= 1'b1;
               req_op <= active_cmd.op;
               req_now_time_ms <= active_cmd.now_time_ms;
               req_allow_start <= active_cmd.allow_start;
               req_allow_run <= active_cmd.allow_run;
               req_want_stop <= active_cmd.want_stop;
               req_want_close <= active_cmd.want_close;
               req_fault_in <= active_cmd.fault_in;
               req_hal_ok <= active_cmd.hal_ok;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // report monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      vms_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_reports.size() == 0) begin
               $error("report with no command waiting");
               mismatch_count++;
            end else begin
               want = awaited_reports.pop_front();
               check_field("status_code", 32'(want.status_code), 32'(rsp_status_code));
               check_field("ctrl_state", 32'(want.ctrl_state), 32'(rsp_ctrl_state));
               check_field("motion_dir", 32'(want.motion_dir), 32'(rsp_motion_dir));
               check_field("motor_on", 32'(want.motor_on), 32'(rsp_motor_on));
               check_field("blocked", 32'(want.blocked), 32'(rsp_blocked));
               check_field("run_time_ms", want.run_time_ms, rsp_run_time_ms);
               check_field("ops_done", want.ops_done, rsp_ops_done);
               check_field("last_dir", 32'(want.last_dir), 32'(rsp_last_dir));
               check_field("driver_actions", 32'(want.driver_actions),
                           32'(rsp_driver_actions));
               check_field("drive_duty", 32'(want.drive_duty), 32'(rsp_drive_duty));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      logic [6:0] duty;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // duty above range while the directed part runs
      write_duty(($urandom() & 32'hffff_ff80) | 32'd127);

      // unused opcode with every flag set, tick with nothing running
      queue_cmd(OP_UNUSED, 32'h0000_0000, 1, 1, 1, 1, 1, 1);
      queue_cmd(OP_UPDATE, 32'h0000_0000, 0, 0, 0, 0, 0, 1);
      // open near the top of the clock, runtime wraps
      queue_cmd(OP_OPEN, 32'hffff_fff0, 0, 0, 0, 0, 0, 1);
      queue_cmd(OP_UPDATE, 32'h0000_0010, 0, 0, 0, 0, 0, 1);
      queue_cmd(OP_OPEN, 32'h0000_0020, 0, 0, 0, 0, 0, 1);
      queue_cmd(OP_RESET_CYCLE, 32'h0000_0020, 0, 0, 0, 0, 0, 1);
      // failed stop leaves stopping, then a clean stop and a force safe
      queue_cmd(OP_STOP, 32'h0000_0030, 0, 0, 0, 0, 0, 0);
      queue_cmd(OP_STOP, 32'h0000_0040, 0, 0, 0, 0, 0, 1);
      queue_cmd(OP_STOP, 32'h0000_0050, 0, 0, 0, 0, 0, 1);
      // failed start, then close at the top of the clock
      queue_cmd(OP_CLOSE, 32'h0000_0060, 0, 0, 0, 0, 0, 0);
      queue_cmd(OP_CLOSE, 32'hffff_ffff, 0, 0, 0, 0, 0, 1);
      queue_cmd(OP_UPDATE, 32'h0000_0100, 0, 0, 0, 0, 0, 1);
      // failed force safe on a fault keeps runtime
      queue_cmd(OP_SAFETY, 32'h0000_0200, 1, 1, 0, 0, 1, 0);
      queue_cmd(OP_CLEAR_FAULT, 32'h0000_0210, 0, 0, 0, 0, 0, 0);
      queue_cmd(OP_CLEAR_FAULT, 32'h0000_0220, 0, 0, 0, 0, 0, 1);
      queue_cmd(OP_CLEAR_FAULT, 32'h0000_0230, 0, 0, 0, 0, 0, 1);
      queue_cmd(OP_OPEN, 32'h0000_0240, 0, 0, 0, 0, 0, 1);
      // release block, refused safety close, close bypassing the block
      queue_cmd(OP_SAFETY, 32'h0000_0250, 1, 1, 0, 0, 0, 1);
      queue_cmd(OP_SAFETY, 32'h0000_0260, 1, 0, 0, 1, 0, 1);
      queue_cmd(OP_SAFETY, 32'h0000_0270, 0, 1, 0, 1, 0, 1);
      queue_cmd(OP_SAFETY, 32'h0000_0280, 1, 0, 0, 0, 0, 1);
      // failed force safe from a safety stop latches fault
      queue_cmd(OP_SAFETY, 32'h0000_0290, 1, 1, 1, 0, 0, 0);
      queue_cmd(OP_RESET_CYCLE, 32'h0000_02a0, 0, 0, 0, 0, 0, 1);
      queue_cmd(OP_SAFETY, 32'h0000_02b0, 1, 1, 0, 0, 1, 1);
      queue_cmd(OP_CLEAR_FAULT, 32'h0000_02c0, 0, 0, 0, 0, 0, 1);
      queue_cmd(OP_RESET_CYCLE, 32'h0000_02d0, 0, 0, 0, 0, 0, 1);
      wait_drained();

      // random phases, each with its duty and one of four idling patterns
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         duty = (p < 6) ? DUTY_PLAN[p] : 7'($urandom_range(127));
         write_duty(($urandom() & 32'hffff_ff80) | {25'd0, duty});
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) command_queue.push_back(random_cmd());
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
